// ===== rtl/core/sha1_message_digest_assert.svh =====
// ---------------------------------------------------------------------------
// SHA-1 message digest: assertion macros
// Shared property shapes, clocked on i_clk and masked while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// same-cycle implication
`define SHA1_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sha1_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-1 package
// Word type, initial vector, round constants and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package sha1_pkg;

    typedef logic [31:0] t_word;
    typedef logic [6:0]  t_round;
    typedef logic [5:0]  t_pos;

    localparam int     NUM_WORDS  = 5;
    localparam t_round LAST_ROUND = 7'd79;
    localparam t_round ROUND_K1   = 7'd20;
    localparam t_round ROUND_K2   = 7'd40;
    localparam t_round ROUND_K3   = 7'd60;

    localparam t_word SHA1_IV [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        BSEL_MSG  = 2'd0,
        BSEL_MARK = 2'd1,
        BSEL_ZERO = 2'd2,
        BSEL_LEN  = 2'd3
    } t_byte_sel;

    typedef struct packed {
        logic      shift_en;    // shift one byte into the block buffer
        t_byte_sel byte_sel;
        logic      count_inc;   // message byte counted
        logic      comp_start;  // load working words, clear round counter
        logic      round_en;    // run one round
        logic      add_en;      // fold working words into chaining words
        logic      final_load;  // with add_en: capture digest, restart message
    } t_dp_cmd;

    typedef struct packed {
        logic pos_end;     // buffer position is 63
        logic pos_hi;      // buffer position is 56 or above
        logic round_last;  // round counter at 79
    } t_dp_sts;

endpackage

// ===== rtl/core/sha1_message_digest.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message digest
// Byte-stream SHA-1 hash with padding, one digest beat per message.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats carry one message byte in s_axis_tdata when s_axis_tuser is
//   high; s_axis_tlast closes the message (with or without a byte, so an
//   empty message is a single beat with tuser low and tlast high).
//   The output beat carries the five chaining words, word 0 in the lowest
//   bits, each most significant byte first in digest order.
// Timing:
//   Bytes are taken one per cycle while the buffer fills. The 64th byte of
//   a block starts the 80 rounds and then the chaining update, during
//   which s_axis_tready is low; the block rate is set by the single shared
//   round unit. After tlast, padding is shifted in one byte a cycle (split
//   over two blocks when the length spills into a second block) and then
//   the last block is compressed.
// Reset and stalls:
//   Reset returns the chaining words to the initial vector and clears the
//   byte count. The digest sits in an output register, so the next message
//   is taken while it waits; only the final update of a following message
//   holds until the waiting digest has been taken.
// ---------------------------------------------------------------------------
module sha1_message_digest #(
    parameter int LENGTH_COUNTER_BITS = 61
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] byte_present
    input  logic         s_axis_tlast,   // end_of_message
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata    // digest_word0 .. digest_word4, 32 bits each
);
    import sha1_pkg::*;

    `include "sha1_message_digest_assert.svh"

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .i_byte_present   (s_axis_tuser),
        .i_end_of_message (s_axis_tlast),
        .o_in_ready       (s_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .i_sts            (w_sts),
        .o_cmd            (w_cmd)
    );

    sha1_dp #(
        .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_byte (s_axis_tdata),
        .o_sts       (w_sts),
        .o_digest    (m_axis_tdata)
    );

    // a compression only ever starts on the last byte of a block
    `SHA1_ASSERT_IMP(a_comp_full_block, w_cmd.comp_start, w_sts.pos_end, "compression on partial block")
    // exactly 80 rounds: none after the last one
    `SHA1_ASSERT_NEXT(a_round_stop, w_cmd.round_en && w_sts.round_last, !w_cmd.round_en, "round overrun")
    // no intake while the round unit or chaining update is busy
    `SHA1_ASSERT_IMP(a_no_intake_busy, s_axis_tready, !w_cmd.round_en && !w_cmd.add_en, "intake during compression")

endmodule

// ===== rtl/core/sha1_dp.sv =====
// ---------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer doubling as the 16-word schedule window, one shared round
// unit, chaining words, byte counter and the digest output register.
// ---------------------------------------------------------------------------
module sha1_dp #(
    parameter int LENGTH_COUNTER_BITS = 61
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]        i_data_byte,
    output sha1_pkg::t_dp_sts o_sts,
    output logic [159:0]      o_digest
);
    import sha1_pkg::*;

    localparam int BLK_BITS = 512;

    logic [BLK_BITS-1:0]            r_blk;
    t_pos                           r_pos;
    logic [LENGTH_COUNTER_BITS-1:0] r_count;
    t_round                         r_round;
    t_word                          r_a, r_b, r_c, r_d, r_e;
    t_word                          r_h [NUM_WORDS];
    logic [159:0]                   r_dig;

    logic [63:0] w_bits;
    logic [7:0]  w_len_byte;
    logic [7:0]  w_byte;
    t_word       w_w0, w_w2, w_w8, w_w13, w_x, w_new;
    t_word       w_f, w_k, w_t;
    t_word       w_sum [NUM_WORDS];

    // length field: byte count times eight, big-endian, byte picked by position
    assign w_bits     = 64'(r_count) << 3;
    assign w_len_byte = w_bits[{~r_pos[2:0], 3'b000} +: 8];

    always_comb begin
        case (i_cmd.byte_sel)
            BSEL_MSG:  w_byte = i_data_byte;
            BSEL_MARK: w_byte = PAD_MARK;
            BSEL_ZERO: w_byte = 8'h00;
            BSEL_LEN:  w_byte = w_len_byte;
            default:   w_byte = 8'h00;
        endcase
    end

    // schedule taps: word 0 is the oldest
    assign w_w0  = r_blk[BLK_BITS-1      -: 32];
    assign w_w2  = r_blk[BLK_BITS-1-64   -: 32];
    assign w_w8  = r_blk[BLK_BITS-1-256  -: 32];
    assign w_w13 = r_blk[BLK_BITS-1-416  -: 32];
    assign w_x   = w_w13 ^ w_w8 ^ w_w2 ^ w_w0;
    assign w_new = {w_x[30:0], w_x[31]};

    // round function and constant
    always_comb begin
        if (r_round < ROUND_K1) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (r_round < ROUND_K2) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_round < ROUND_K3) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_w0;

    assign w_sum[0] = r_h[0] + r_a;
    assign w_sum[1] = r_h[1] + r_b;
    assign w_sum[2] = r_h[2] + r_c;
    assign w_sum[3] = r_h[3] + r_d;
    assign w_sum[4] = r_h[4] + r_e;

    // buffer: bytes shift in during fill, schedule words during rounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            r_blk <= {r_blk[BLK_BITS-9:0], w_byte};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[BLK_BITS-33:0], w_new};
        end
    end

    // working words and round counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_a     <= r_h[0];
            r_b     <= r_h[1];
            r_c     <= r_h[2];
            r_d     <= r_h[3];
            r_e     <= r_h[4];
            r_round <= '0;
        end else if (i_cmd.round_en) begin
            r_a     <= w_t;
            r_b     <= r_a;
            r_c     <= {r_b[1:0], r_b[31:2]};
            r_d     <= r_c;
            r_e     <= r_d;
            r_round <= r_round + 7'd1;
        end
    end

    // buffer position and message length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.shift_en) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.add_en && i_cmd.final_load) begin
                r_count <= '0;
            end else if (i_cmd.count_inc) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // chaining words, back to the initial vector after each message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_h[i] <= SHA1_IV[i];
            end
        end else if (i_cmd.add_en) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_h[i] <= i_cmd.final_load ? SHA1_IV[i] : w_sum[i];
            end
        end
    end

    // digest register, word 0 lowest
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_en && i_cmd.final_load) begin
            r_dig <= {w_sum[4], w_sum[3], w_sum[2], w_sum[1], w_sum[0]};
        end
    end

    assign o_digest         = r_dig;
    assign o_sts.pos_end    = (r_pos == 6'd63);
    assign o_sts.pos_hi     = (r_pos[5:3] == 3'b111);
    assign o_sts.round_last = (r_round == LAST_ROUND);

endmodule

// ===== rtl/core/sha1_ctrl.sv =====
// ---------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds and the chaining update,
// and owns the input and output handshakes.
// ---------------------------------------------------------------------------
module sha1_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_byte_present,
    input  logic              i_end_of_message,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sha1_pkg::t_dp_sts i_sts,
    output sha1_pkg::t_dp_cmd o_cmd
);
    import sha1_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PAD   = 4'b0010,
        S_ROUND = 4'b0100,
        S_ADD   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_last_pend, n_last_pend;  // padding still owed after this block
    logic   r_mark_done, n_mark_done;  // 0x80 already written
    logic   r_len_ok,    n_len_ok;     // length field fits in this block
    logic   r_final,     n_final;      // block in flight is the last one
    logic   r_out_valid, n_out_valid;

    logic   w_accept;
    logic   w_out_busy;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;
    assign w_out_busy = r_out_valid && !i_out_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_last_pend = r_last_pend;
        n_mark_done = r_mark_done;
        n_len_ok    = r_len_ok;
        n_final     = r_final;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.byte_sel = BSEL_MSG;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_end_of_message) begin
                        n_mark_done = 1'b0;
                    end
                    if (i_byte_present) begin
                        o_cmd.shift_en  = 1'b1;
                        o_cmd.count_inc = 1'b1;
                        if (i_sts.pos_end) begin
                            o_cmd.comp_start = 1'b1;
                            n_last_pend      = i_end_of_message;
                            n_final          = 1'b0;
                            n_state          = S_ROUND;
                        end else if (i_end_of_message) begin
                            n_state = S_PAD;
                        end
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.shift_en = 1'b1;
                if (!r_mark_done) begin
                    o_cmd.byte_sel = BSEL_MARK;
                    n_len_ok       = !i_sts.pos_hi;
                end else if (i_sts.pos_hi && r_len_ok) begin
                    o_cmd.byte_sel = BSEL_LEN;
                end else begin
                    o_cmd.byte_sel = BSEL_ZERO;
                end
                n_mark_done = 1'b1;
                if (i_sts.pos_end) begin
                    o_cmd.comp_start = 1'b1;
                    n_final          = (o_cmd.byte_sel == BSEL_LEN);
                    n_last_pend      = 1'b1;
                    n_len_ok         = 1'b1;
                    n_state          = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (i_sts.round_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                // last block waits for the digest register to drain
                if (!(r_final && w_out_busy)) begin
                    o_cmd.add_en     = 1'b1;
                    o_cmd.final_load = r_final;
                    if (r_final) begin
                        n_out_valid = 1'b1;
                        n_last_pend = 1'b0;
                        n_state     = S_IDLE;
                    end else if (r_last_pend) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_pend <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_ok    <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_pend <= n_last_pend;
            r_mark_done <= n_mark_done;
            r_len_ok    <= n_len_ok;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
